// ----- rtl/dpwp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dpwp_pkg;

  // Image bounds; a pixel at or beyond them is dropped.
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRows = 1024;
  localparam int unsigned ImgIdxW = 13;

  localparam int unsigned ColW    = 10;
  localparam int unsigned RowW    = 10;
  localparam int unsigned DepthW  = 16;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned RgbW    = 3 * ColorW;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned RegW    = 32;
  localparam int unsigned InDataW = 64;
  localparam int unsigned OutDataW = 3 * CoordW + RgbW;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_QUAT_W  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_QUAT_X  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_QUAT_Y  = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_QUAT_Z  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_TRANS_X = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_TRANS_Y = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_TRANS_Z = 3'd6;

  // Quaternion component slots.
  localparam int unsigned QW = 0;
  localparam int unsigned QX = 1;
  localparam int unsigned QY = 2;
  localparam int unsigned QZ = 3;

  // Quaternion product terms: xx, yy, zz, xy, xz, yz, xw, yw, zw.
  localparam int unsigned T_XX = 0;
  localparam int unsigned T_YY = 1;
  localparam int unsigned T_ZZ = 2;
  localparam int unsigned T_XY = 3;
  localparam int unsigned T_XZ = 4;
  localparam int unsigned T_YZ = 5;
  localparam int unsigned T_XW = 6;
  localparam int unsigned T_YW = 7;
  localparam int unsigned T_ZW = 8;
  localparam int unsigned NumTerms = 9;
  localparam int unsigned TermA [NumTerms] = '{QX, QY, QZ, QX, QX, QY, QX, QY, QZ};
  localparam int unsigned TermB [NumTerms] = '{QX, QY, QZ, QY, QZ, QZ, QW, QW, QW};

  localparam int unsigned NumStages = 7;

  // Doubled principal point.
  localparam int unsigned U2W = ColW + 2;
  localparam logic [U2W-1:0] CenterU2 = 12'd651;
  localparam logic [U2W-1:0] CenterV2 = 12'd507;

  // Back-projection: q = floor(((P << DivShift) + DivBias) / DivDen), with P = |offset| * depth.
  localparam int unsigned MagW   = 11;
  localparam int unsigned ProdW  = MagW + DepthW;
  localparam int unsigned RecipW = 24;
  localparam int unsigned PkW    = ProdW + RecipW;
  localparam int unsigned EstW   = 23;
  localparam int unsigned NumW   = 40;
  localparam int unsigned DenW   = 16;
  localparam int unsigned CamW   = 24;

  localparam int unsigned DivShift      [3] = '{11, 12, 13};
  localparam int unsigned DivRecipShift [3] = '{27, 27, 16};
  localparam logic [DenW-1:0] DivDen  [3] = '{16'd32375, 16'd64875, 16'd125};
  localparam logic [DenW-1:0] DivBias [3] = '{16'd16187, 16'd32437, 16'd62};
  localparam logic [RecipW-1:0] DivRecip [3] = '{
    RecipW'((64'd1 << 38) / 64'd32375),
    RecipW'((64'd1 << 39) / 64'd64875),
    RecipW'((64'd1 << 29) / 64'd125)
  };

  // Rotation matrix arithmetic.
  localparam int unsigned QProdW = 64;
  localparam int unsigned TermW  = 34;
  localparam int unsigned RotW   = 36;
  localparam int unsigned MprodW = RotW + CamW;
  localparam int unsigned AccW   = MprodW + 2;
  localparam int unsigned SumW   = 34;

  typedef logic signed [RegW-1:0]   reg_t;
  typedef logic signed [QProdW-1:0] qprod_t;
  typedef logic signed [TermW-1:0]  term_t;
  typedef logic signed [RotW-1:0]   rot_t;
  typedef logic signed [CamW-1:0]   cam_t;
  typedef logic signed [MprodW-1:0] mprod_t;
  typedef logic signed [AccW-1:0]   acc_t;
  typedef logic signed [SumW-1:0]   sum_t;

  localparam qprod_t QProdRound = QProdW'(1) <<< 29;
  localparam rot_t   RotOne     = RotW'(1) <<< 30;
  localparam acc_t   AccRound   = AccW'(1) <<< 29;
  localparam sum_t   SatMax     = SumW'(32'sh7FFF_FFFF);
  localparam sum_t   SatMin     = SumW'(32'sh8000_0000);
  localparam reg_t   QuatWReset = 32'sh4000_0000;

endpackage

`default_nettype wire

// ----- rtl/depth_pixel_to_world_point.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A kept pixel moves through the stage registers and is on out_tvalid from the last
// stage, from which it can leave when out_tready is high.
// Throughput: one beat per cycle unless the output stalls, when empty stages close up.
// Pixels with zero depth or outside the image give no output beat.
// The rotation matrix follows a quaternion write via registered products, terms, entries.
// Reset (synchronous, rst_n low) empties the pipeline and sets an identity pose.

module depth_pixel_to_world_point
  import dpwp_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_wr_en,
  input  wire [CfgAddrW-1:0]  cfg_addr,
  input  wire [RegW-1:0]      cfg_wdata,
  input  wire                 in_tvalid,
  output logic                in_tready,
  // col, row, depth_raw, red_in, green_in, blue_in, four zero bits
  input  wire [InDataW-1:0]   in_tdata,
  output logic                out_tvalid,
  input  wire                 out_tready,
  // world_x, world_y, world_z, red_out, green_out, blue_out
  output logic [OutDataW-1:0] out_tdata
);

  reg_t   quat_r  [4];
  reg_t   trans_r [3];
  qprod_t qprod_r [NumTerms];
  term_t  term_r  [NumTerms];
  rot_t   rot_r   [3][3];

  qprod_t qprod_nxt [NumTerms];
  term_t  term_nxt  [NumTerms];
  rot_t   rot_nxt   [3][3];

  logic [NumStages:1] vld_r;
  logic [NumStages:1] stage_en;
  logic [RgbW-1:0]    rgb_r [1:NumStages];

  logic [ProdW-1:0] prod1_r [3];
  logic [2:0]       neg1_r;
  logic [PkW-1:0]   pk2_r   [3];
  logic [ProdW-1:0] prod2_r [3];
  logic [2:0]       neg2_r;
  logic [EstW-1:0]  est3_r  [3];
  logic [NumW-1:0]  estd3_r [3];
  logic [NumW-1:0]  num3_r  [3];
  logic [2:0]       neg3_r;
  cam_t             cam_r   [3];
  mprod_t           mprod_r [3][3];
  acc_t             acc_r   [3];
  logic [CoordW-1:0] world_r [3];

  logic [ColW-1:0]   in_col;
  logic [RowW-1:0]   in_row;
  logic [DepthW-1:0] in_depth;
  logic              keep;

  logic [ProdW-1:0]  prod1_nxt [3];
  logic [2:0]        neg1_nxt;
  logic [PkW-1:0]    pk2_nxt   [3];
  logic [EstW-1:0]   est3_nxt  [3];
  logic [NumW-1:0]   estd3_nxt [3];
  logic [NumW-1:0]   num3_nxt  [3];
  cam_t              cam_nxt   [3];
  mprod_t            mprod_nxt [3][3];
  acc_t              acc_nxt   [3];
  logic [CoordW-1:0] world_nxt [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_r[QW] <= QuatWReset;
      quat_r[QX] <= '0;
      quat_r[QY] <= '0;
      quat_r[QZ] <= '0;
      trans_r[0] <= '0;
      trans_r[1] <= '0;
      trans_r[2] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_QUAT_W:  quat_r[QW] <= cfg_wdata;
        REG_QUAT_X:  quat_r[QX] <= cfg_wdata;
        REG_QUAT_Y:  quat_r[QY] <= cfg_wdata;
        REG_QUAT_Z:  quat_r[QZ] <= cfg_wdata;
        REG_TRANS_X: trans_r[0] <= cfg_wdata;
        REG_TRANS_Y: trans_r[1] <= cfg_wdata;
        REG_TRANS_Z: trans_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Rotation matrix from the quaternion: products, rounding, then matrix entries.
  always_comb begin
    for (int k = 0; k < NumTerms; k++) begin
      qprod_nxt[k] = quat_r[TermA[k]] * quat_r[TermB[k]];
      term_nxt[k]  = TermW'((qprod_r[k] + QProdRound) >>> 30);
    end
  end

  always_comb begin
    rot_t t [NumTerms];
    for (int k = 0; k < NumTerms; k++) begin
      t[k] = RotW'(term_r[k]);
    end
    rot_nxt[0][0] = RotOne - ((t[T_YY] + t[T_ZZ]) <<< 1);
    rot_nxt[0][1] = (t[T_XY] - t[T_ZW]) <<< 1;
    rot_nxt[0][2] = (t[T_XZ] + t[T_YW]) <<< 1;
    rot_nxt[1][0] = (t[T_XY] + t[T_ZW]) <<< 1;
    rot_nxt[1][1] = RotOne - ((t[T_XX] + t[T_ZZ]) <<< 1);
    rot_nxt[1][2] = (t[T_YZ] - t[T_XW]) <<< 1;
    rot_nxt[2][0] = (t[T_XZ] - t[T_YW]) <<< 1;
    rot_nxt[2][1] = (t[T_YZ] + t[T_XW]) <<< 1;
    rot_nxt[2][2] = RotOne - ((t[T_XX] + t[T_YY]) <<< 1);
  end

  always_ff @(posedge clk) begin
    qprod_r <= qprod_nxt;
    term_r  <= term_nxt;
    rot_r   <= rot_nxt;
  end

  // Stage handshake: a stage loads when it is empty or its successor loads.
  always_comb begin
    stage_en[NumStages] = !vld_r[NumStages] || out_tready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  assign in_tready = stage_en[1];

  assign in_col   = in_tdata[ColW-1:0];
  assign in_row   = in_tdata[ColW+RowW-1:ColW];
  assign in_depth = in_tdata[ColW+RowW+DepthW-1:ColW+RowW];
  assign keep     = (in_depth != '0) && (ImgIdxW'(in_col) < ImgIdxW'(MaxCols))
                    && (ImgIdxW'(in_row) < ImgIdxW'(MaxRows));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stage_en[1]) begin
        vld_r[1] <= in_tvalid && keep;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      rgb_r[1] <= in_tdata[ColW+RowW+DepthW+RgbW-1:ColW+RowW+DepthW];
    end
    for (int k = 2; k <= NumStages; k++) begin
      if (stage_en[k]) begin
        rgb_r[k] <= rgb_r[k-1];
      end
    end
  end

  // Stage 1: offset magnitude times depth.
  always_comb begin
    logic [U2W-1:0]  u2;
    logic [U2W-1:0]  v2;
    logic [MagW-1:0] mag_u;
    logic [MagW-1:0] mag_v;
    u2 = {1'b0, in_col, 1'b0};
    v2 = {1'b0, in_row, 1'b0};
    neg1_nxt[0] = u2 < CenterU2;
    neg1_nxt[1] = v2 < CenterV2;
    neg1_nxt[2] = 1'b0;
    mag_u = neg1_nxt[0] ? MagW'(CenterU2 - u2) : MagW'(u2 - CenterU2);
    mag_v = neg1_nxt[1] ? MagW'(CenterV2 - v2) : MagW'(v2 - CenterV2);
    prod1_nxt[0] = ProdW'(mag_u) * ProdW'(in_depth);
    prod1_nxt[1] = ProdW'(mag_v) * ProdW'(in_depth);
    prod1_nxt[2] = ProdW'(in_depth);
  end

  // Stages 2 to 4: division by constants through a reciprocal and a remainder fix-up.
  always_comb begin
    logic [NumW-1:0] rem;
    logic [EstW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      pk2_nxt[i]   = PkW'(prod1_r[i]) * PkW'(DivRecip[i]);
      est3_nxt[i]  = EstW'(pk2_r[i] >> DivRecipShift[i]);
      estd3_nxt[i] = NumW'(est3_nxt[i]) * NumW'(DivDen[i]);
      num3_nxt[i]  = (NumW'(prod2_r[i]) << DivShift[i]) + NumW'(DivBias[i]);
      rem = num3_r[i] - estd3_r[i];
      q = est3_r[i] + EstW'(rem >= NumW'(DivDen[i]))
          + EstW'(rem >= (NumW'(DivDen[i]) << 1));
      cam_nxt[i] = neg3_r[i] ? -CamW'(q) : CamW'(q);
    end
  end

  // Stages 5 to 7: matrix product, row sums, rounding, translation and saturation.
  always_comb begin
    sum_t s;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mprod_nxt[i][j] = rot_r[i][j] * cam_r[j];
      end
      acc_nxt[i] = mprod_r[i][0] + mprod_r[i][1] + mprod_r[i][2];
      s = SumW'((acc_r[i] + AccRound) >>> 30) + SumW'(trans_r[i]);
      if (s > SatMax) begin
        world_nxt[i] = CoordW'(SatMax);
      end else if (s < SatMin) begin
        world_nxt[i] = CoordW'(SatMin);
      end else begin
        world_nxt[i] = CoordW'(s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      prod1_r <= prod1_nxt;
      neg1_r  <= neg1_nxt;
    end
    if (stage_en[2]) begin
      pk2_r   <= pk2_nxt;
      prod2_r <= prod1_r;
      neg2_r  <= neg1_r;
    end
    if (stage_en[3]) begin
      est3_r  <= est3_nxt;
      estd3_r <= estd3_nxt;
      num3_r  <= num3_nxt;
      neg3_r  <= neg2_r;
    end
    if (stage_en[4]) begin
      cam_r <= cam_nxt;
    end
    if (stage_en[5]) begin
      mprod_r <= mprod_nxt;
    end
    if (stage_en[6]) begin
      acc_r <= acc_nxt;
    end
    if (stage_en[7]) begin
      world_r <= world_nxt;
    end
  end

  assign out_tvalid = vld_r[NumStages];
  assign out_tdata  = {rgb_r[NumStages], world_r[2], world_r[1], world_r[0]};

  // A pixel without depth never enters the pipeline.
  a_zero_depth_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[ColW+RowW+DepthW-1:ColW+RowW] == '0)
    |=> !vld_r[1])
    else $error("zero-depth pixel entered the pipeline");

  // A held stage keeps its beat.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && !stage_en[3] |=> vld_r[3])
    else $error("stalled beat lost in stage three");

  // Camera depth of a kept pixel is strictly positive.
  a_depth_positive: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] |-> !cam_r[2][CamW-1] && (cam_r[2] != '0))
    else $error("camera depth not positive");

endmodule

`default_nettype wire

// ----- bench/depth_pixel_to_world_point_test.sv -----
`timescale 1ns / 1ps

module depth_pixel_to_world_point_test;
  import dpwp_pkg::*;

  localparam int unsigned Latency      = 7;
  localparam int unsigned SettleCycles = Latency + 3;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned NumRegs      = 7;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhasePixels  = 100;
  localparam int unsigned MaxReports   = 40;
  localparam logic [CfgAddrW-1:0] RegUnused = 3'd7;

  localparam longint DenX   = 1036000;
  localparam longint DenY   = 1038000;
  localparam longint DenZ   = 1000;
  localparam longint OneQ30 = 64'sd1 <<< 30;
  localparam longint Coord32Max = 64'sd2147483647;
  localparam longint Coord32Min = -64'sd2147483648;

  localparam reg_t QuatOne    = 32'sh4000_0000;
  localparam reg_t QuatMinus  = 32'shC000_0000;
  localparam reg_t CoordTop   = 32'sh7FFF_FFFF;
  localparam reg_t CoordFloor = 32'sh8000_0000;

  typedef struct packed {
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [DepthW-1:0] depth;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } pixel_t;

  typedef struct {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [ColorW-1:0]        red;
    logic [ColorW-1:0]        green;
    logic [ColorW-1:0]        blue;
  } point_t;

  class point_cloud_board;
    reg_t        pose_reg [NumRegs];
    point_t      pending_points [$];
    int unsigned mismatches;
    int unsigned points_seen;

    function new();
      foreach (pose_reg[i]) pose_reg[i] = '0;
      pose_reg[REG_QUAT_W] = QuatWReset;
      mismatches  = 0;
      points_seen = 0;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, reg_t val);
      if (idx <= REG_TRANS_Z) pose_reg[idx] = val;
    endfunction

    function longint round_shift30(longint v);
      longint biased;
      biased = v + (64'sd1 <<< 29);
      return biased >>> 30;
    endfunction

    function longint div_nearest(longint num, longint den);
      longint mag;
      longint quo;
      mag = (num < 0) ? -num : num;
      quo = (mag + den / 2) / den;
      return (num < 0) ? -quo : quo;
    endfunction

    function longint clamp32(longint v);
      if (v > Coord32Max) return Coord32Max;
      if (v < Coord32Min) return Coord32Min;
      return v;
    endfunction

    function bit project_pixel(pixel_t p, output point_t pt);
      longint scaled;
      longint cam [3];
      longint q [4];
      longint m [3][3];
      longint res [3];
      longint acc;
      longint txx, tyy, tzz, txy, txz, tyz, txw, tyw, tzw;
      if (p.depth == 0 || p.col >= MaxCols || p.row >= MaxRows) return 0;
      scaled = longint'(p.depth) <<< 16;
      cam[2] = div_nearest(scaled, DenZ);
      cam[0] = div_nearest((2 * longint'(p.col) - longint'(CenterU2)) * scaled, DenX);
      cam[1] = div_nearest((2 * longint'(p.row) - longint'(CenterV2)) * scaled, DenY);
      q[QW] = longint'(pose_reg[REG_QUAT_W]);
      q[QX] = longint'(pose_reg[REG_QUAT_X]);
      q[QY] = longint'(pose_reg[REG_QUAT_Y]);
      q[QZ] = longint'(pose_reg[REG_QUAT_Z]);
      txx = round_shift30(q[QX] * q[QX]);
      tyy = round_shift30(q[QY] * q[QY]);
      tzz = round_shift30(q[QZ] * q[QZ]);
      txy = round_shift30(q[QX] * q[QY]);
      txz = round_shift30(q[QX] * q[QZ]);
      tyz = round_shift30(q[QY] * q[QZ]);
      txw = round_shift30(q[QX] * q[QW]);
      tyw = round_shift30(q[QY] * q[QW]);
      tzw = round_shift30(q[QZ] * q[QW]);
      m[0][0] = OneQ30 - 2 * (tyy + tzz);
      m[0][1] = 2 * (txy - tzw);
      m[0][2] = 2 * (txz + tyw);
      m[1][0] = 2 * (txy + tzw);
      m[1][1] = OneQ30 - 2 * (txx + tzz);
      m[1][2] = 2 * (tyz - txw);
      m[2][0] = 2 * (txz - tyw);
      m[2][1] = 2 * (tyz + txw);
      m[2][2] = OneQ30 - 2 * (txx + tyy);
      for (int i = 0; i < 3; i++) begin
        acc = m[i][0] * cam[0] + m[i][1] * cam[1] + m[i][2] * cam[2];
        res[i] = clamp32(round_shift30(acc) + longint'(pose_reg[REG_TRANS_X + i]));
      end
      pt.x     = CoordW'(res[0]);
      pt.y     = CoordW'(res[1]);
      pt.z     = CoordW'(res[2]);
      pt.red   = p.red;
      pt.green = p.green;
      pt.blue  = p.blue;
      return 1;
    endfunction

    function void take_pixel(pixel_t p);
      point_t pt;
      if (project_pixel(p, pt)) pending_points = {pending_points, pt};
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (mismatches < MaxReports)
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_point(logic [OutDataW-1:0] beat);
      point_t got;
      point_t want;
      longint got_f [6];
      longint want_f [6];
      string  field_name [6];
      got.x     = beat[CoordW-1:0];
      got.y     = beat[2*CoordW-1:CoordW];
      got.z     = beat[3*CoordW-1:2*CoordW];
      got.red   = beat[3*CoordW+ColorW-1:3*CoordW];
      got.green = beat[3*CoordW+2*ColorW-1:3*CoordW+ColorW];
      got.blue  = beat[3*CoordW+3*ColorW-1:3*CoordW+2*ColorW];
      points_seen++;
      if (pending_points.size() == 0) begin
        report_mismatch("beat with no point pending (world_x)", got.x, 0);
        return;
      end
      want = pending_points.pop_front();
      field_name = '{"world_x", "world_y", "world_z", "red_out", "green_out", "blue_out"};
      got_f  = '{got.x, got.y, got.z, got.red, got.green, got.blue};
      want_f = '{want.x, want.y, want.z, want.red, want.green, want.blue};
      for (int i = 0; i < 6; i++) begin
        if (got_f[i] !== want_f[i]) report_mismatch(field_name[i], got_f[i], want_f[i]);
      end
    endtask

    task flush_leftover();
      point_t want;
      while (pending_points.size() != 0) begin
        want = pending_points.pop_front();
        report_mismatch("point never emitted (world_x)", 0, want.x);
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [RegW-1:0]     cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;

  point_cloud_board sb;
  reg_t             next_pose [NumRegs];
  int unsigned      gap_pct;
  int unsigned      stall_pct;
  int unsigned      pixels_sent;
  int unsigned      poses_used;
  int unsigned      quiet_cycles;

  depth_pixel_to_world_point dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic pixel_t make_pixel(int unsigned col, int unsigned row,
                                        int unsigned depth, int unsigned red,
                                        int unsigned green, int unsigned blue);
    pixel_t p;
    p.col   = ColW'(col);
    p.row   = RowW'(row);
    p.depth = DepthW'(depth);
    p.red   = ColorW'(red);
    p.green = ColorW'(green);
    p.blue  = ColorW'(blue);
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    int unsigned depth;
    case ($urandom_range(0, 9))
      0:       depth = 0;
      1:       depth = $urandom_range(1, 65535);
      2:       depth = $urandom_range(0, 1) ? 65535 : 1;
      default: depth = $urandom_range(300, 10000);
    endcase
    return make_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), depth,
                      $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255));
  endfunction

  function automatic reg_t pick_quat_part();
    case ($urandom_range(0, 5))
      0:       return QuatOne;
      1:       return QuatMinus;
      2:       return '0;
      default: return reg_t'(longint'($urandom_range(0, 32'h8000_0000)) - OneQ30);
    endcase
  endfunction

  function automatic reg_t pick_offset();
    case ($urandom_range(0, 4))
      0:       return CoordTop;
      1:       return CoordFloor;
      2:       return reg_t'($urandom());
      default: return reg_t'(int'($urandom_range(0, 20 * 65536)) - 10 * 65536);
    endcase
  endfunction

  // Half-angle cosine and sine pairs in Q2.30 for rotations about one axis.
  function automatic void pick_pose();
    reg_t half_cos [4];
    reg_t half_sin [4];
    int unsigned k;
    int unsigned axis;
    half_cos = '{QuatOne, 32'sd759250125, 32'sd929887697, 32'sd0};
    half_sin = '{32'sd0, 32'sd759250125, 32'sd536870912, QuatOne};
    if ($urandom_range(0, 2) == 0) begin
      k    = $urandom_range(0, 3);
      axis = $urandom_range(1, 3);
      foreach (next_pose[i]) next_pose[i] = '0;
      next_pose[REG_QUAT_W] = $urandom_range(0, 1) ? -half_cos[k] : half_cos[k];
      next_pose[axis]       = $urandom_range(0, 1) ? -half_sin[k] : half_sin[k];
    end else begin
      next_pose[REG_QUAT_W] = pick_quat_part();
      next_pose[REG_QUAT_X] = pick_quat_part();
      next_pose[REG_QUAT_Y] = pick_quat_part();
      next_pose[REG_QUAT_Z] = pick_quat_part();
    end
    next_pose[REG_TRANS_X] = pick_offset();
    next_pose[REG_TRANS_Y] = pick_offset();
    next_pose[REG_TRANS_Z] = pick_offset();
  endfunction

  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= InDataW'({p.blue, p.green, p.red, p.depth, p.row, p.col});
    do @(posedge clk); while (!in_tready);
    sb.take_pixel(p);
    pixels_sent++;
  endtask

  task automatic drain_points();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_points.size() != 0);
    repeat (Latency + 2) @(posedge clk);
  endtask

  task automatic write_pose(input bit poke_unused);
    for (int i = 0; i < NumRegs; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= CfgAddrW'(i);
      cfg_wdata <= next_pose[i];
      sb.set_reg(CfgAddrW'(i), next_pose[i]);
      @(posedge clk);
    end
    if (poke_unused) begin
      cfg_addr  <= RegUnused;
      cfg_wdata <= $urandom();
      sb.set_reg(RegUnused, reg_t'(32'h1234_5678));
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    poses_used++;
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Result side: random back-pressure, now and then a long stall.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 299) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_point(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QuietLimit);
    $display("tb: no beat for %0d cycles", QuietLimit);
    $display("tb: failure");
    $finish;
  end

  initial begin
    sb           = new();
    gap_pct      = 0;
    stall_pct    = 0;
    pixels_sent  = 0;
    poses_used   = 0;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity pose out of reset: image corners, the principal point, depth
    // extremes and pixels without a depth reading.
    send_pixel(make_pixel(0, 0, 1, 0, 0, 0));
    send_pixel(make_pixel(1023, 1023, 65535, 255, 255, 255));
    send_pixel(make_pixel(325, 253, 1000, 170, 85, 15));
    send_pixel(make_pixel(326, 254, 1000, 85, 170, 240));
    send_pixel(make_pixel(0, 0, 0, 255, 255, 255));
    send_pixel(make_pixel(1023, 0, 0, 1, 2, 3));
    send_pixel(make_pixel(512, 512, 1, 128, 64, 32));
    send_pixel(make_pixel(0, 1023, 65535, 7, 8, 9));
    send_pixel(make_pixel(1023, 0, 32768, 200, 100, 50));
    send_pixel(make_pixel(700, 100, 999, 11, 22, 33));
    send_pixel(make_pixel(5, 600, 1001, 44, 55, 66));
    send_pixel(make_pixel(682, 341, 21845, 85, 85, 85));
    send_pixel(make_pixel(341, 682, 43690, 170, 170, 170));
    drain_points();

    // Half turn about z with translations at both bounds, so that far points
    // saturate; a write to the unused index must leave the pose alone.
    next_pose = '{32'sd0, 32'sd0, 32'sd0, QuatOne, CoordTop, CoordFloor, 32'sd0};
    write_pose(1'b1);
    send_pixel(make_pixel(0, 1023, 65535, 12, 34, 56));
    send_pixel(make_pixel(1023, 0, 65535, 65, 43, 21));
    send_pixel(make_pixel(325, 253, 0, 90, 90, 90));
    drain_points();

    // A quaternion far from unit length, every part at the negative bound.
    next_pose = '{QuatMinus, QuatMinus, QuatMinus, QuatMinus, 32'sd0, 32'sd0, 32'sd0};
    write_pose(1'b0);
    send_pixel(make_pixel(1023, 1023, 65535, 1, 1, 1));
    send_pixel(make_pixel(0, 0, 65535, 254, 254, 254));
    drain_points();

    for (int ph = 0; ph < NumPhases; ph++) begin
      pick_pose();
      write_pose(ph % 4 == 0);
      case (ph % 3)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 20;
          stall_pct = 20;
        end
        default: begin
          gap_pct   = 50;
          stall_pct = 40;
        end
      endcase
      for (int n = 0; n < PhasePixels; n++) send_pixel(random_pixel());
      drain_points();
    end

    stall_pct = 0;
    drain_points();
    sb.flush_leftover();
    $display("tb: %0d pixels sent under %0d poses, %0d points checked",
             pixels_sent, poses_used, sb.points_seen);
    $display("tb: covered corners, zero depth, saturation, non-unit quaternions, stalls");
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
